/* hdl/fmpp_pkg.sv */
// Shared types and constants for the four-motor pattern PWM driver.
// No dependencies; imported by the top level and its checker.
package fmpp_pkg;

  // Speed level and phase widths, fixed by the motor port layout
  localparam int LEVEL_W       = 3;
  localparam int PHASE_W       = 4;
  localparam int PATTERN_W     = 16;
  localparam int PATTERN_COUNT = 7;
  localparam int CFG_IDX_W     = 3;
  localparam int PORT_W        = 8;
  localparam int SPEED_W       = 8;
  localparam int INDEX_W       = 8;
  localparam int READ_W        = 4;
  localparam int MAX_MOTORS    = 4;

  typedef logic [PATTERN_W-1:0] pattern_t;
  typedef logic [LEVEL_W-1:0]   level_t;

  // Transaction kinds carried on tuser
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SET    = 2'd1,
    KIND_READ   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  // Pattern words loaded at reset, one per speed level
  localparam pattern_t PATTERN_RESET [PATTERN_COUNT] = '{
    16'h0000, 16'h8080, 16'h8888, 16'hAAAA, 16'hEEEE, 16'hFEFE, 16'hFFFF
  };

endpackage

/* hdl/four_motor_pattern_pwm.sv */
// Four-motor pattern PWM driver: input register, single-pass update, result register.
// Depends on fmpp_pkg for kinds, widths and the reset pattern table.
//
// A transaction waits in the input register until the result register is free.
// Throughput: one transaction per cycle unless the result side stalls; a stalled
// result blocks new input. All rst work is synchronous: pattern words return to
// their defaults, motors to level 0 forward, phase and port to 0.
module four_motor_pattern_pwm
  import fmpp_pkg::*;
#(
  parameter int NUM_MOTORS = 4,
  parameter int MAX_LEVEL  = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // [7:0] motor_index, [15:8] speed_request
  input  logic [1:0]           s_tuser,   // [1:0] kind
  // Result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [7:0] port_value, [11:8] read_speed, [15:12] zero
  // Configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PATTERN_W-1:0] cfg_data
);

  // Input register
  logic               in_valid;
  kind_t              in_kind;
  logic [INDEX_W-1:0] in_index;
  logic [SPEED_W-1:0] in_speed;

  // Block state
  pattern_t           pattern_reg  [PATTERN_COUNT];
  level_t             speed_level  [NUM_MOTORS];
  logic               reverse_flag [NUM_MOTORS];
  logic [PHASE_W-1:0] phase;
  logic [PORT_W-1:0]  port_latch;

  // Combinational results
  logic               advance;
  logic               do_set;
  logic               do_tick;
  logic               neg;
  logic [SPEED_W-1:0] mag;
  level_t             sat_level;
  level_t             speed_level_next  [NUM_MOTORS];
  logic               reverse_flag_next [NUM_MOTORS];
  logic [7:0]         phase_bits;
  logic [PORT_W-1:0]  port_next;
  logic [READ_W-1:0]  read_speed;
  logic [PORT_W-1:0]  port_value;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Hold the accepted transaction until the result register can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind  <= kind_t'(s_tuser);
      in_index <= s_tdata[7:0];
      in_speed <= s_tdata[15:8];
    end
  end

  // Decode the kind; the unused code behaves as a read
  always_comb begin
    do_set  = 1'b0;
    do_tick = 1'b0;
    case (in_kind)
      KIND_TICK: begin
        do_tick = 1'b1;
      end
      KIND_SET: begin
        do_set  = 1'b1;
        do_tick = 1'b1;
      end
      default: begin
        do_set  = 1'b0;
        do_tick = 1'b0;
      end
    endcase
  end

  // Saturate the magnitude of the requested speed; -128 gives 128 and saturates
  always_comb begin
    neg       = in_speed[SPEED_W-1];
    mag       = neg ? (~in_speed + SPEED_W'(1)) : in_speed;
    sat_level = (mag > SPEED_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : mag[LEVEL_W-1:0];
  end

  // Update the addressed motor; out-of-range indexes match no motor
  always_comb begin
    for (int m = 0; m < NUM_MOTORS; m++) begin
      if (do_set && (in_index == INDEX_W'(m))) begin
        speed_level_next[m]  = sat_level;
        reverse_flag_next[m] = neg;
      end else begin
        speed_level_next[m]  = speed_level[m];
        reverse_flag_next[m] = reverse_flag[m];
      end
    end
  end

  // Sample every pattern word at the current phase; level 7 has no pattern
  always_comb begin
    phase_bits = '0;
    for (int l = 0; l < PATTERN_COUNT; l++) begin
      phase_bits[l] = pattern_reg[l][phase];
    end
  end

  // Build the new port byte from each motor's level and direction
  always_comb begin
    port_next = '0;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      if (phase_bits[speed_level_next[m]]) begin
        port_next[MAX_MOTORS + m] = 1'b1;
        port_next[m]              = reverse_flag_next[m];
      end
    end
  end

  // Signed speed of the addressed motor after the update
  always_comb begin
    read_speed = '0;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      if (in_index == INDEX_W'(m)) begin
        read_speed = reverse_flag_next[m] ? (READ_W'(0) - {1'b0, speed_level_next[m]})
                                          : {1'b0, speed_level_next[m]};
      end
    end
  end

  assign port_value = do_tick ? port_next : port_latch;

  // Pattern words: written from the configuration port, indexes past the table dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < PATTERN_COUNT; l++) begin
        pattern_reg[l] <= PATTERN_RESET[l];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(PATTERN_COUNT))) begin
      pattern_reg[cfg_index] <= cfg_data;
    end
  end

  // Motor state, phase and port latch advance as the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        speed_level[m]  <= '0;
        reverse_flag[m] <= 1'b0;
      end
      phase      <= '0;
      port_latch <= '0;
    end else if (advance) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        speed_level[m]  <= speed_level_next[m];
        reverse_flag[m] <= reverse_flag_next[m];
      end
      if (do_tick) begin
        phase      <= phase + PHASE_W'(1);
        port_latch <= port_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'b0000, read_speed, port_value};
    end
  end

endmodule

/* hdl/fmpp_checker.sv */
// Port-level checks for the four-motor pattern PWM driver.
// Depends on fmpp_pkg; bound to four_motor_pattern_pwm below.
module fmpp_checker
  import fmpp_pkg::*;
#(
  parameter int MAX_LEVEL = 6
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // No result straight after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid in the cycle after reset");

  // A reverse bit only ever comes with its on bit
  a_reverse_with_on: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[3:0] & ~m_tdata[7:4]) == 4'b0000))
    else $error("reverse bit set without on bit");

  // Read speed stays within the saturated range
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (($signed(m_tdata[11:8]) >= -MAX_LEVEL) &&
                  ($signed(m_tdata[11:8]) <= MAX_LEVEL)))
    else $error("read speed out of range");

  // Padding bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:12] == 4'b0000))
    else $error("result padding not zero");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind four_motor_pattern_pwm fmpp_checker #(.MAX_LEVEL(MAX_LEVEL)) u_fmpp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* bench/fmpp_result_check.sv */
// Result checker for the four-motor pattern PWM driver: predicts each port byte
// and read-back speed from the input stream and configuration writes.
// Depends on fmpp_pkg for kinds, widths and the reset pattern table.
`timescale 1ns / 100ps

module fmpp_result_check
  import fmpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [15:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [15:0]          m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PATTERN_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  localparam int REPORT_LIMIT = 10;
  localparam int TOP_LEVEL    = 6;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [READ_W-1:0] speed;
  } motor_result_t;

  // Predicted driver state
  pattern_t           pattern_word [PATTERN_COUNT];
  level_t             level        [MAX_MOTORS];
  logic               reversed     [MAX_MOTORS];
  logic [PHASE_W-1:0] phase;
  logic [PORT_W-1:0]  port_byte;

  motor_result_t pending_results [$];
  int            fail_total = 0;

  // Sample every motor's pattern at the current phase, then advance the phase
  task automatic advance_port();
    logic [PORT_W-1:0] next_byte;
    pattern_t          word;
    next_byte = '0;
    for (int m = 0; m < MAX_MOTORS; m++) begin
      word = (level[m] < PATTERN_COUNT) ? pattern_word[level[m]] : '0;
      if (word[phase]) begin
        next_byte[4 + m] = 1'b1;
        if (reversed[m]) next_byte[m] = 1'b1;
      end
    end
    phase     = phase + 1'b1;
    port_byte = next_byte;
  endtask

  // Apply one input transaction to the predicted state and form its result
  task automatic predict_item(input kind_t kind, input logic [INDEX_W-1:0] idx,
                              input logic [SPEED_W-1:0] request,
                              output motor_result_t result);
    logic               addressed;
    logic [SPEED_W-1:0] magnitude;
    addressed = (idx < MAX_MOTORS);
    case (kind)
      KIND_SET: begin
        if (addressed) begin
          // -128 negates to 128, which saturates like any large magnitude
          magnitude = request[SPEED_W-1] ? SPEED_W'(0 - request) : request;
          if (magnitude > TOP_LEVEL) magnitude = SPEED_W'(TOP_LEVEL);
          level[idx[1:0]]    = level_t'(magnitude);
          reversed[idx[1:0]] = request[SPEED_W-1];
        end
        advance_port();
      end
      KIND_TICK: advance_port();
      default: ;  // read and unused kinds leave the state alone
    endcase
    result.port  = port_byte;
    result.speed = '0;
    if (addressed)
      result.speed = reversed[idx[1:0]] ? READ_W'(0 - level[idx[1:0]])
                                        : READ_W'(level[idx[1:0]]);
  endtask

  always @(posedge clk) begin
    motor_result_t want;
    motor_result_t got;
    if (rst) begin
      for (int i = 0; i < PATTERN_COUNT; i++) pattern_word[i] = PATTERN_RESET[i];
      for (int m = 0; m < MAX_MOTORS; m++) begin
        level[m]    = '0;
        reversed[m] = 1'b0;
      end
      phase     = '0;
      port_byte = '0;
      pending_results.delete();
    end else begin
      // Pattern writes; indexes past the table are dropped
      if (cfg_we && cfg_index < PATTERN_COUNT) pattern_word[cfg_index] = cfg_data;

      // Compare a result transaction with the oldest prediction
      if (m_tvalid && m_tready) begin
        got.port  = m_tdata[PORT_W-1:0];
        got.speed = m_tdata[PORT_W +: READ_W];
        if (pending_results.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT)
            $display("unexpected result: port %h read_speed %0d",
                     got.port, $signed(got.speed));
        end else begin
          want = pending_results.pop_front();
          if (got.port !== want.port || got.speed !== want.speed) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
              $display("result mismatch: port exp %h got %h, read_speed exp %0d got %0d",
                       want.port, got.port, $signed(want.speed), $signed(got.speed));
          end
        end
      end

      // Predict an input transaction
      if (s_tvalid && s_tready) begin
        predict_item(kind_t'(s_tuser), s_tdata[INDEX_W-1:0],
                     s_tdata[INDEX_W +: SPEED_W], want);
        pending_results.push_back(want);
      end
    end
    fail_count  <= fail_total;
    outstanding <= pending_results.size();
  end

endmodule

/* bench/tb_four_motor_pattern_pwm.sv */
// Top of the four-motor pattern PWM driver bench: clock, reset, stimulus and verdict.
// Depends on fmpp_pkg, four_motor_pattern_pwm and fmpp_result_check.
`timescale 1ns / 100ps

module tb_four_motor_pattern_pwm;
  import fmpp_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int ITEMS_PER_SET = 84;
  localparam int IDLE_PCT      = 27;
  localparam int SETTLE_CYCLES = 8;

  // Pattern tables loaded between phases of the run
  typedef enum int {
    PAT_INVERTED,
    PAT_ALL_ZERO,
    PAT_ALL_ONE,
    PAT_RANDOM,
    PAT_SINGLE_BIT
  } pattern_set_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata   = '0;
  logic [1:0]           s_tuser   = KIND_TICK;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [15:0]          m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PATTERN_W-1:0] cfg_data  = '0;
  logic                 steady    = 1'b0;
  int                   fail_count;
  int                   outstanding;
  int                   cycle_count = 0;

  always #2 clk = ~clk;

  four_motor_pattern_pwm DUT (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  fmpp_result_check motor_check (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .outstanding
  );

  // Stall the result side at random, except through the steady stretch
  always @(posedge clk)
    m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one input transaction, with a random gap ahead of it outside the steady stretch
  task automatic send_item(input kind_t kind, input logic [INDEX_W-1:0] idx,
                           input logic [SPEED_W-1:0] request);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {request, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Mostly valid motors, with the odd wild index; half the speeds small, half wild
  task automatic send_random();
    int                 pick;
    kind_t              kind;
    logic [INDEX_W-1:0] idx;
    logic [SPEED_W-1:0] request;
    pick = $urandom_range(0, 99);
    kind = (pick < 40) ? KIND_SET : (pick < 70) ? KIND_TICK :
           (pick < 92) ? KIND_READ : KIND_UNUSED;
    idx  = ($urandom_range(0, 9) < 8) ? INDEX_W'($urandom_range(0, MAX_MOTORS - 1))
                                      : INDEX_W'($urandom);
    request = ($urandom_range(0, 1) == 0) ? SPEED_W'(int'($urandom_range(0, 14)) - 7)
                                          : SPEED_W'($urandom);
    send_item(kind, idx, request);
  endtask

  // Hold input until every result is back, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all seven pattern words, then one write past the table
  task automatic load_patterns(input pattern_set_t set);
    pattern_t word;
    for (int i = 0; i < PATTERN_COUNT; i++) begin
      case (set)
        PAT_INVERTED:   word = ~PATTERN_RESET[i];
        PAT_ALL_ZERO:   word = '0;
        PAT_ALL_ONE:    word = '1;
        PAT_SINGLE_BIT: word = pattern_t'(1) << (i * 2 + 1);
        default:        word = pattern_t'($urandom);
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= word;
      @(posedge clk);
    end
    cfg_index <= CFG_IDX_W'(PATTERN_COUNT);
    cfg_data  <= pattern_t'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset state, saturation, full reverse, zero, bad indexes, kinds
    send_item(KIND_TICK,   8'd0,   8'd0);
    for (int m = 0; m < MAX_MOTORS; m++) send_item(KIND_READ, INDEX_W'(m), 8'd0);
    send_item(KIND_SET,    8'd0,   8'sd127);
    send_item(KIND_SET,    8'd1,   8'h80);
    send_item(KIND_SET,    8'd2,   -8'sd3);
    send_item(KIND_SET,    8'd3,   8'd0);
    send_item(KIND_SET,    8'd2,   8'h81);
    send_item(KIND_SET,    8'd4,   8'd5);
    send_item(KIND_SET,    8'd255, 8'hFF);
    send_item(KIND_READ,   8'd255, 8'd0);
    send_item(KIND_READ,   8'd4,   8'd0);
    send_item(KIND_UNUSED, 8'd1,   8'h7F);
    send_item(KIND_READ,   8'd1,   8'd0);
    send_item(KIND_SET,    8'd3,   8'd7);
    send_item(KIND_SET,    8'd0,   -8'sd6);
    send_item(KIND_SET,    8'd0,   8'd1);
    send_item(KIND_SET,    8'd1,   -8'sd1);
    send_item(KIND_TICK,   8'hAA,  8'h55);
    for (int i = 0; i < 4; i++) send_item(KIND_TICK, 8'd0, 8'd0);

    // Random phases, each under a different pattern table
    for (int i = 0; i < ITEMS_PER_SET; i++) send_random();
    for (int s = PAT_INVERTED; s <= PAT_SINGLE_BIT; s++) begin
      drain();
      load_patterns(pattern_set_t'(s));
      steady <= (s == PAT_RANDOM);
      for (int i = 0; i < ITEMS_PER_SET; i++) send_random();
    end
    steady <= 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/fmpp_pkg.sv
hdl/four_motor_pattern_pwm.sv
hdl/fmpp_checker.sv
bench/fmpp_result_check.sv
bench/tb_four_motor_pattern_pwm.sv
